[rtl/pmst_pkg.sv]
package pmst_pkg;

   // Graph size and field widths.
   localparam int MAX_VERTICES = 64;
   localparam int VERTEX_BITS  = 6;
   localparam int WEIGHT_BITS  = 16;
   localparam int COST_BITS    = WEIGHT_BITS + 1;
   localparam int ADDR_BITS    = 2 * VERTEX_BITS;
   localparam int ADJ_DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int COUNT_BITS   = 7;

   // Cost of a vertex that no tree edge reaches yet.
   localparam logic [COST_BITS-1:0] UNREACHED = COST_BITS'(1) << WEIGHT_BITS;

   // Operation codes of a request.
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]             operation;
      logic [VERTEX_BITS-1:0] vertex_a;
      logic [VERTEX_BITS-1:0] vertex_b;
      logic [WEIGHT_BITS-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] tree_from;
      logic [VERTEX_BITS-1:0] tree_to;
      logic [WEIGHT_BITS-1:0] tree_weight;
      logic                   edge_valid;
      logic                   disconnected;
      logic                   last;
   } rsp_type;

   // One adjacency entry: a present bit and the edge weight.
   typedef struct packed {
      logic                   present;
      logic [WEIGHT_BITS-1:0] weight;
   } adj_entry_type;

   // Write command to the adjacency store; clear writes an absent entry.
   typedef struct packed {
      logic                   en;
      logic                   clear;
      logic [VERTEX_BITS-1:0] a;
      logic [VERTEX_BITS-1:0] b;
      logic [WEIGHT_BITS-1:0] weight;
   } adj_wr_type;

   // Control of the relaxation and selection pass.
   typedef struct packed {
      logic                   start;
      logic                   issue;
      logic                   init;
      logic [VERTEX_BITS-1:0] vertex;
      logic [VERTEX_BITS-1:0] index;
   } relax_ctrl_type;

   // Result of a pass: the cheapest unvisited vertex, if any.
   typedef struct packed {
      logic                   found;
      logic [VERTEX_BITS-1:0] sel;
      logic [VERTEX_BITS-1:0] source;
      logic [COST_BITS-1:0]   cost;
   } relax_stat_type;

endpackage

[rtl/pmst_adj_store.sv]
module pmst_adj_store
   import pmst_pkg::*;
(
   input  logic                   clock,
   input  adj_wr_type             wr,
   input  logic [VERTEX_BITS-1:0] rd_u,
   input  logic [VERTEX_BITS-1:0] rd_i,
   output adj_entry_type          rd_data
);

   // The graph is undirected, so both directions share one entry
   // addressed by the smaller endpoint first.
   function automatic logic [ADDR_BITS-1:0] pair_addr(
      input logic [VERTEX_BITS-1:0] x,
      input logic [VERTEX_BITS-1:0] y
   );
      logic [ADDR_BITS-1:0] addr;
      if (x < y) begin
         addr = {x, y};
      end else begin
         addr = {y, x};
      end
      return addr;
   endfunction

   adj_entry_type mem [ADJ_DEPTH];
   adj_entry_type rd_data_ff;
   adj_entry_type wr_entry;

   assign wr_entry.present = !wr.clear;
   assign wr_entry.weight  = wr.weight;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[pair_addr(wr.a, wr.b)] <= wr_entry;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[pair_addr(rd_u, rd_i)];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pmst_relax_unit.sv]
module pmst_relax_unit
   import pmst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  relax_ctrl_type          ctrl,
   input  adj_entry_type           adj,
   input  logic [MAX_VERTICES-1:0] visited,
   output relax_stat_type          stat
);

   typedef struct packed {
      logic [COST_BITS-1:0]   cost;
      logic [VERTEX_BITS-1:0] source;
   } best_type;

   best_type mem [MAX_VERTICES];
   best_type rd_ff;

   logic                   s1_valid_ff;
   logic                   s1_init_ff;
   logic [VERTEX_BITS-1:0] s1_index_ff;
   logic [VERTEX_BITS-1:0] s1_vertex_ff;

   relax_stat_type stat_ff;
   relax_stat_type stat_in;

   logic                 s1_visited;
   logic [COST_BITS-1:0] edge_cost;
   best_type             best_new;

   // Read the current best entry alongside the adjacency read.
   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         rd_ff <= mem[ctrl.index];
      end
      s1_init_ff   <= ctrl.init;
      s1_index_ff  <= ctrl.index;
      s1_vertex_ff <= ctrl.vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.issue;
      end
   end

   // Relax one neighbor: the first pass loads the row of vertex zero,
   // later passes keep a strictly smaller edge weight.
   assign s1_visited = visited[s1_index_ff];
   assign edge_cost  = {1'b0, adj.weight};

   always_comb begin
      if (s1_init_ff) begin
         best_new.cost   = adj.present ? edge_cost : UNREACHED;
         best_new.source = '0;
      end else if (adj.present && !s1_visited && (edge_cost < rd_ff.cost)) begin
         best_new.cost   = edge_cost;
         best_new.source = s1_vertex_ff;
      end else begin
         best_new = rd_ff;
      end
   end

   // Write back; the next read is always to a different entry.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem[s1_index_ff] <= best_new;
      end
   end

   // Track the cheapest unvisited vertex, lowest index first on ties.
   always_comb begin
      stat_in = stat_ff;
      if (ctrl.start) begin
         stat_in.found = 1'b0;
         stat_in.cost  = UNREACHED;
      end else if (s1_valid_ff && !s1_visited && (best_new.cost < stat_ff.cost)) begin
         stat_in.found  = 1'b1;
         stat_in.sel    = s1_index_ff;
         stat_in.source = best_new.source;
         stat_in.cost   = best_new.cost;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff.found <= 1'b0;
      end else begin
         stat_ff.found <= stat_in.found;
      end
      stat_ff.sel    <= stat_in.sel;
      stat_ff.source <= stat_in.source;
      stat_ff.cost   <= stat_in.cost;
   end

   assign stat = stat_ff;

endmodule

[rtl/prim_minimum_spanning_tree_core.sv]
// Dense minimum spanning tree engine over up to 64 vertices.
// Requests are accepted on a rising edge with start high and busy low;
// req_data.operation selects add edge, run or clear. An add writes one
// shared entry of the adjacency memory and keeps busy low, so adds can
// follow one per cycle. A clear sweeps all 4096 entries, one per cycle,
// with busy high; the same sweep runs right after reset.
// A run grows the tree from vertex zero over vertex_count vertices,
// clamped to the range 1 to 64. Each pass reads one adjacency row and
// the best-cost memory, one vertex per cycle, relaxing and picking the
// next vertex in the same sweep. Each tree edge appears on rsp_data for
// one cycle with rsp_valid high; the final result of a run has last set,
// and an unreachable vertex ends the run with an invalid result marked
// disconnected. The receiver cannot stall, so results are never held.
// The user must write vertex_count with csr_we only while the block is
// idle; the block itself does not enforce it. Reset sets vertex_count to one.
module prim_minimum_spanning_tree_core
   import pmst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [COUNT_BITS-1:0] csr_wdata
);

   state_type state_ff;
   state_type state_in;

   logic [COUNT_BITS-1:0]   vertex_count_ff;
   logic [ADDR_BITS-1:0]    clr_ff;
   logic [VERTEX_BITS-1:0]  idx_ff;
   logic [VERTEX_BITS-1:0]  u_ff;
   logic [VERTEX_BITS-1:0]  edges_ff;
   logic                    init_ff;
   logic                    single_ff;
   logic [MAX_VERTICES-1:0] visited_ff;

   logic [COUNT_BITS-1:0]  n_clamped;
   logic [COUNT_BITS-1:0]  n_minus_one;
   logic [VERTEX_BITS-1:0] last_idx;
   logic                   accept;
   logic                   run_req;
   logic                   emit_edge;
   logic                   emit_last;
   logic                   next_pass;

   adj_wr_type     adj_wr;
   adj_entry_type  adj_rd;
   relax_ctrl_type relax_ctrl;
   relax_stat_type relax_stat;

   // Vertex count in use, clamped to one through the store size.
   always_comb begin
      if (vertex_count_ff == '0) begin
         n_clamped = COUNT_BITS'(1);
      end else if (vertex_count_ff > COUNT_BITS'(MAX_VERTICES)) begin
         n_clamped = COUNT_BITS'(MAX_VERTICES);
      end else begin
         n_clamped = vertex_count_ff;
      end
   end

   assign n_minus_one = n_clamped - COUNT_BITS'(1);
   assign last_idx    = n_minus_one[VERTEX_BITS-1:0];

   assign accept  = start && (state_ff == ST_IDLE);
   assign run_req = accept && (req_data.operation == OP_RUN);

   // Outcome of a finished pass.
   assign emit_edge = !single_ff && relax_stat.found;
   assign emit_last = single_ff || !relax_stat.found
                      || ((edges_ff + VERTEX_BITS'(1)) == last_idx);
   assign next_pass = (state_ff == ST_EMIT) && !emit_last;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_RUN:   state_in = (last_idx == '0) ? ST_EMIT : ST_SCAN;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = emit_last ? ST_IDLE : ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory commands and handshake outputs.
   always_comb begin
      adj_wr.en     = 1'b0;
      adj_wr.clear  = 1'b0;
      adj_wr.a      = req_data.vertex_a;
      adj_wr.b      = req_data.vertex_b;
      adj_wr.weight = req_data.edge_weight;
      if (state_ff == ST_CLEAR) begin
         adj_wr.en    = 1'b1;
         adj_wr.clear = 1'b1;
         adj_wr.a     = clr_ff[ADDR_BITS-1:VERTEX_BITS];
         adj_wr.b     = clr_ff[VERTEX_BITS-1:0];
      end else if (accept && (req_data.operation == OP_ADD)) begin
         adj_wr.en = 1'b1;
      end

      relax_ctrl.start  = run_req || next_pass;
      relax_ctrl.issue  = (state_ff == ST_SCAN);
      relax_ctrl.init   = init_ff;
      relax_ctrl.vertex = u_ff;
      relax_ctrl.index  = idx_ff;

      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);

      rsp_data.edge_valid   = emit_edge;
      rsp_data.disconnected = !single_ff && !relax_stat.found;
      rsp_data.last         = emit_last;
      if (emit_edge) begin
         rsp_data.tree_from   = relax_stat.source;
         rsp_data.tree_to     = relax_stat.sel;
         rsp_data.tree_weight = relax_stat.cost[WEIGHT_BITS-1:0];
      end else begin
         rsp_data.tree_from   = '0;
         rsp_data.tree_to     = '0;
         rsp_data.tree_weight = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         vertex_count_ff <= COUNT_BITS'(1);
         clr_ff          <= '0;
         visited_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            vertex_count_ff <= csr_wdata;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_BITS'(1);
         end else begin
            clr_ff <= '0;
         end
         if (run_req) begin
            visited_ff <= MAX_VERTICES'(1);
         end else if ((state_ff == ST_EMIT) && emit_edge) begin
            visited_ff[relax_stat.sel] <= 1'b1;
         end
      end
   end

   // Pass bookkeeping.
   always_ff @(posedge clock) begin
      if (run_req) begin
         idx_ff    <= '0;
         u_ff      <= '0;
         init_ff   <= 1'b1;
         edges_ff  <= '0;
         single_ff <= (last_idx == '0);
      end else if (next_pass) begin
         idx_ff   <= '0;
         u_ff     <= relax_stat.sel;
         init_ff  <= 1'b0;
         edges_ff <= edges_ff + VERTEX_BITS'(1);
      end else if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + VERTEX_BITS'(1);
      end
   end

   pmst_adj_store u_adj_store (
      .clock   (clock),
      .wr      (adj_wr),
      .rd_u    (u_ff),
      .rd_i    (idx_ff),
      .rd_data (adj_rd)
   );

   pmst_relax_unit u_relax_unit (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (relax_ctrl),
      .adj     (adj_rd),
      .visited (visited_ff),
      .stat    (relax_stat)
   );

endmodule

[tb/sv/tb_prim_minimum_spanning_tree_core.sv]
`timescale 1ns / 1ps

module tb_prim_minimum_spanning_tree_core;
   import pmst_pkg::*;

   // The fourth operation code has no meaning; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int REQUEST_TARGET = 350;

   typedef enum bit {ROW_CONFIG, ROW_REQUEST} row_kind_type;

   // One step of stimulus: a vertex count write or a request, with an
   // optional result that is known without running the predictor.
   typedef struct {
      row_kind_type          kind;
      logic [COUNT_BITS-1:0] count;
      req_type               req;
      bit                    typed;
      rsp_type               want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [COUNT_BITS-1:0] csr_wdata;

   prim_minimum_spanning_tree_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the graph and of the vertex count register.
   bit                    edge_on [MAX_VERTICES][MAX_VERTICES];
   logic [WEIGHT_BITS-1:0] edge_wt [MAX_VERTICES][MAX_VERTICES];
   logic [COUNT_BITS-1:0] model_count;

   // Working state of one predicted run.
   logic [COST_BITS-1:0]   cost_at   [MAX_VERTICES];
   logic [VERTEX_BITS-1:0] source_at [MAX_VERTICES];
   bit                     in_tree   [MAX_VERTICES];

   rsp_type tree_edges[$];     // results computed for the latest request
   rsp_type pending_edges[$];  // results still owed by the block

   int burst_left;
   int requests_sent;
   bit failed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Number of vertices that a run actually covers.
   function automatic int effective_count(logic [COUNT_BITS-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_VERTICES) return MAX_VERTICES;
      return int'(count);
   endfunction

   // Lower the cost of every unvisited neighbor of v on a strictly smaller weight.
   function automatic void relax_from(int v, int n);
      for (int i = 0; i < n; i++) begin
         if (edge_on[v][i] && !in_tree[i] && {1'b0, edge_wt[v][i]} < cost_at[i]) begin
            cost_at[i]   = {1'b0, edge_wt[v][i]};
            source_at[i] = v[VERTEX_BITS-1:0];
         end
      end
   endfunction

   // Apply one request to the shadow graph and list the results it causes.
   function automatic void prim_predict(req_type r);
      int n;
      int sel;
      bit stop;
      bit found;
      logic [COST_BITS-1:0] min_cost;
      rsp_type res;
      tree_edges.delete();
      case (r.operation)
         OP_ADD: begin
            edge_on[r.vertex_a][r.vertex_b] = 1'b1;
            edge_wt[r.vertex_a][r.vertex_b] = r.edge_weight;
            edge_on[r.vertex_b][r.vertex_a] = 1'b1;
            edge_wt[r.vertex_b][r.vertex_a] = r.edge_weight;
         end
         OP_CLEAR: begin
            foreach (edge_on[i, j]) begin
               edge_on[i][j] = 1'b0;
               edge_wt[i][j] = '0;
            end
         end
         OP_RUN: begin
            n = effective_count(model_count);
            foreach (cost_at[i]) begin
               cost_at[i]   = UNREACHED;
               source_at[i] = '0;
               in_tree[i]   = 1'b0;
            end
            cost_at[0] = '0;
            in_tree[0] = 1'b1;
            sel = 0;
            stop = 1'b0;
            for (int k = 1; k <= n && !stop; k++) begin
               relax_from(sel, n);
               if (k == n) break;
               // Strictly smallest cost wins, so the lowest index keeps a tie.
               min_cost = UNREACHED;
               found = 1'b0;
               for (int i = 0; i < n; i++) begin
                  if (!in_tree[i] && cost_at[i] < min_cost) begin
                     min_cost = cost_at[i];
                     sel = i;
                     found = 1'b1;
                  end
               end
               res = '0;
               if (!found) begin
                  res.disconnected = 1'b1;
                  res.last = 1'b1;
                  stop = 1'b1;
               end else begin
                  in_tree[sel]    = 1'b1;
                  res.tree_from   = source_at[sel];
                  res.tree_to     = sel[VERTEX_BITS-1:0];
                  res.tree_weight = cost_at[sel][WEIGHT_BITS-1:0];
                  res.edge_valid  = 1'b1;
                  res.last        = (k + 1 == n);
               end
               tree_edges.push_back(res);
            end
            // A single vertex yields one result that carries no edge.
            if (n == 1) begin
               res = '0;
               res.last = 1'b1;
               tree_edges.push_back(res);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic plan_row_type config_row(int count);
      plan_row_type row;
      row = '{kind: ROW_CONFIG, count: count[COUNT_BITS-1:0], req: '0, typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic plan_row_type request_row(logic [1:0] op, int a, int b, int w);
      plan_row_type row;
      row = '{kind: ROW_REQUEST, count: '0, req: '0, typed: 1'b0, want: '0};
      row.req.operation   = op;
      row.req.vertex_a    = a[VERTEX_BITS-1:0];
      row.req.vertex_b    = b[VERTEX_BITS-1:0];
      row.req.edge_weight = w[WEIGHT_BITS-1:0];
      return row;
   endfunction

   // A run whose single result is written out by hand.
   function automatic plan_row_type run_expecting(int from, int to, int w, bit valid,
                                                  bit disc, bit last);
      plan_row_type row;
      row = request_row(OP_RUN, 0, 0, 0);
      row.typed = 1'b1;
      row.want.tree_from    = from[VERTEX_BITS-1:0];
      row.want.tree_to      = to[VERTEX_BITS-1:0];
      row.want.tree_weight  = w[WEIGHT_BITS-1:0];
      row.want.edge_valid   = valid;
      row.want.disconnected = disc;
      row.want.last         = last;
      return row;
   endfunction

   // Weights lean toward the extremes and toward a few small values that tie.
   function automatic int draw_weight();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 65535;
         2, 3, 4: return $urandom_range(0, 3);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Stop sending and wait until the block owes nothing and has gone idle.
   task automatic settle_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Write the vertex count register, or send one request in a burst and
   // record what it should produce once the block takes it.
   task automatic apply_row(plan_row_type row);
      int gap;
      if (row.kind == ROW_CONFIG) begin
         settle_idle();
         csr_we    <= 1'b1;
         csr_wdata <= row.count;
         @(posedge clock);
         csr_we <= 1'b0;
         model_count = row.count;
      end else begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
         start    <= 1'b1;
         req_data <= row.req;
         do @(posedge clock); while (busy !== 1'b0);
         prim_predict(row.req);
         if (row.typed) pending_edges.push_back(row.want);
         else foreach (tree_edges[i]) pending_edges.push_back(tree_edges[i]);
         if (row.req.operation != OP_UNUSED) requests_sent++;
      end
   endtask

   task automatic report_field(string name, logic [WEIGHT_BITS-1:0] want,
                               logic [WEIGHT_BITS-1:0] got);
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      failed = 1'b1;
   endtask

   // Every strobed result must match the oldest outstanding one.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_edges.size() == 0) begin
            $display("%0t: result expected none actual %p", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = pending_edges.pop_front();
            if (rsp_data.tree_from !== want.tree_from)
               report_field("tree_from", WEIGHT_BITS'(want.tree_from),
                            WEIGHT_BITS'(rsp_data.tree_from));
            if (rsp_data.tree_to !== want.tree_to)
               report_field("tree_to", WEIGHT_BITS'(want.tree_to),
                            WEIGHT_BITS'(rsp_data.tree_to));
            if (rsp_data.tree_weight !== want.tree_weight)
               report_field("tree_weight", want.tree_weight, rsp_data.tree_weight);
            if (rsp_data.edge_valid !== want.edge_valid)
               report_field("edge_valid", WEIGHT_BITS'(want.edge_valid),
                            WEIGHT_BITS'(rsp_data.edge_valid));
            if (rsp_data.disconnected !== want.disconnected)
               report_field("disconnected", WEIGHT_BITS'(want.disconnected),
                            WEIGHT_BITS'(rsp_data.disconnected));
            if (rsp_data.last !== want.last)
               report_field("last", WEIGHT_BITS'(want.last), WEIGHT_BITS'(rsp_data.last));
         end
      end
   end

   // Hang guard, far above the slowest correct run.
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      plan_row_type plan[$];
      int count;
      int span;
      int u;
      bit flip;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      failed    = 1'b0;
      burst_left    = 0;
      requests_sent = 0;
      model_count   = 1;
      foreach (edge_on[i, j]) begin
         edge_on[i][j] = 1'b0;
         edge_wt[i][j] = '0;
      end

      // Directed requests: defaults after reset, empty and disconnected
      // graphs, count extremes, self loops, ties, overwrites and far edges.
      plan.push_back(run_expecting(0, 0, 0, 1'b0, 1'b0, 1'b1));
      plan.push_back(config_row(64));
      plan.push_back(run_expecting(0, 0, 0, 1'b0, 1'b1, 1'b1));
      plan.push_back(request_row(OP_ADD, 0, 63, 65535));
      plan.push_back(request_row(OP_ADD, 63, 62, 0));
      plan.push_back(request_row(OP_ADD, 5, 5, 7));
      plan.push_back(request_row(OP_UNUSED, 63, 63, 65535));
      plan.push_back(request_row(OP_RUN, 0, 0, 0));
      plan.push_back(config_row(0));
      plan.push_back(run_expecting(0, 0, 0, 1'b0, 1'b0, 1'b1));
      plan.push_back(config_row(127));
      plan.push_back(request_row(OP_RUN, 63, 63, 65535));
      plan.push_back(config_row(3));
      plan.push_back(request_row(OP_ADD, 1, 0, 10));
      plan.push_back(request_row(OP_ADD, 2, 1, 10));
      plan.push_back(request_row(OP_ADD, 2, 0, 10));
      plan.push_back(request_row(OP_ADD, 0, 1, 4));
      plan.push_back(request_row(OP_ADD, 2, 63, 1));
      plan.push_back(request_row(OP_RUN, 0, 0, 0));
      plan.push_back(request_row(OP_CLEAR, 63, 63, 65535));
      plan.push_back(run_expecting(0, 0, 0, 1'b0, 1'b1, 1'b1));
      plan.push_back(config_row(2));
      plan.push_back(request_row(OP_ADD, 1, 0, 0));
      plan.push_back(run_expecting(0, 1, 0, 1'b1, 1'b0, 1'b1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) apply_row(plan[i]);

      // Random graphs: optional clear, optional new vertex count, a spanning tree
      // on half of them, extra edges with some noise, then one or two runs.
      while (requests_sent < REQUEST_TARGET) begin
         if ($urandom_range(0, 3) == 0)
            apply_row(request_row(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                                  draw_weight()));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       count = $urandom_range(33, 64);
               1:       count = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                     : $urandom_range(65, 127);
               default: count = $urandom_range(2, 12);
            endcase
            apply_row(config_row(count));
         end
         span = effective_count(model_count);
         if ($urandom_range(0, 1)) begin
            for (int v = 1; v < span; v++) begin
               u = $urandom_range(0, v - 1);
               flip = ($urandom_range(0, 1) != 0);
               apply_row(request_row(OP_ADD, flip ? u : v, flip ? v : u, draw_weight()));
            end
         end
         repeat ($urandom_range(0, span)) begin
            case ($urandom_range(0, 15))
               0:       apply_row(request_row(OP_UNUSED, $urandom_range(0, 63),
                                              $urandom_range(0, 63), draw_weight()));
               1, 2:    apply_row(request_row(OP_ADD, $urandom_range(0, 63),
                                              $urandom_range(0, 63), draw_weight()));
               default: apply_row(request_row(OP_ADD, $urandom_range(0, span - 1),
                                              $urandom_range(0, span - 1), draw_weight()));
            endcase
         end
         repeat ($urandom_range(1, 2))
            apply_row(request_row(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                                  draw_weight()));
      end

      settle_idle();
      repeat (20) @(posedge clock);
      if (!failed)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
rtl/pmst_pkg.sv
rtl/pmst_adj_store.sv
rtl/pmst_relax_unit.sv
rtl/prim_minimum_spanning_tree_core.sv
tb/sv/tb_prim_minimum_spanning_tree_core.sv
